// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the path search RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while rst is high.
`define GAPS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and disabled while rst is high.
`define GAPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/gaps_pkg.sv =====
// Types, codes and helpers shared by the grid path search modules.
`timescale 1ns / 1ps
`default_nettype none
package gaps_pkg;

  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;

  localparam logic [1:0] KIND_MAP    = 2'd0;
  localparam logic [1:0] KIND_SEARCH = 2'd1;
  localparam logic [1:0] KIND_READ   = 2'd2;
  localparam logic [1:0] KIND_SPARE  = 2'd3;

  localparam logic [1:0] ST_ACK    = 2'd0;
  localparam logic [1:0] ST_FOUND  = 2'd1;
  localparam logic [1:0] ST_NOPATH = 2'd2;
  localparam logic [1:0] ST_BEYOND = 2'd3;

  localparam logic [1:0] DIR_XP = 2'd0;
  localparam logic [1:0] DIR_XM = 2'd1;
  localparam logic [1:0] DIR_YP = 2'd2;
  localparam logic [1:0] DIR_YM = 2'd3;

  localparam logic CFG_GRID_WIDTH  = 1'b0;
  localparam logic CFG_GRID_HEIGHT = 1'b1;

  typedef enum logic [4:0] {
    OP_IDLE, OP_CLEAR, OP_CHECK, OP_PUSH_INIT, OP_PUSH_RD, OP_PUSH_CMP,
    OP_PUSH_PLACE, OP_POP_RD, OP_POP_TOP, OP_SIFT_RD, OP_SIFT_CMP,
    OP_COST_RD, OP_COST_Q, OP_NB, OP_NB_CHK, OP_NEXT_DIR, OP_TR_WR,
    OP_TR_MOV, OP_FINISH
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       idle;
    logic       clr_map;
    logic [1:0] result;
  } cmd_t;

  typedef struct packed {
    logic search_go;
    logic sweep_done;
    logic bad_range;
    logic oc_zero;
    logic oc_one;
    logic parent_le;
    logic par_zero;
    logic sift_stop;
    logic at_goal;
    logic nb_ok;
    logic nb_free;
    logic dir_last;
    logic tr_last;
    logic out_free;
  } stat_t;

  typedef struct packed {
    logic [12:0] f;
    logic [6:0]  h;
    logic [11:0] seq;
    logic [11:0] loc;
  } heap_entry_t;

  function automatic logic [31:0] key_of(input heap_entry_t e);
    return {e.f, e.h, e.seq};
  endfunction

  function automatic logic [5:0] abs_diff(input logic [5:0] a, input logic [5:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gaps_dp.sv =====
// Datapath of the path search: map, search and path memories, heap and output stages.
`timescale 1ns / 1ps
`default_nettype none
module gaps_dp import gaps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cmd_t        cmd,
  output stat_t       st,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic        blocked,
  input  logic [5:0]  start_x,
  input  logic [5:0]  start_y,
  input  logic [5:0]  goal_x,
  input  logic [5:0]  goal_y,
  input  logic [11:0] path_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [12:0] path_length,
  output logic [5:0]  path_x,
  output logic [5:0]  path_y
);

  logic        map_mem  [MAX_WIDTH*MAX_HEIGHT];
  logic        disc_mem [MAX_WIDTH*MAX_HEIGHT];
  logic [11:0] cost_mem [MAX_WIDTH*MAX_HEIGHT];
  logic [1:0]  par_mem  [MAX_WIDTH*MAX_HEIGHT];
  heap_entry_t heap_mem [MAX_WIDTH*MAX_HEIGHT];
  logic [11:0] path_mem [MAX_WIDTH*MAX_HEIGHT];

  logic [6:0]  grid_width, grid_height;
  logic [5:0]  sx, sy, gx, gy;
  logic [11:0] sweep_cnt;
  logic [12:0] open_count;
  logic [11:0] seq;
  logic [11:0] hi, cur, gcur, nbr, tr_cell;
  logic [6:0]  nbr_h;
  logic [12:0] tr_i;
  logic [1:0]  dir;
  logic [12:0] path_count;
  heap_entry_t ne, last, rd_a, rd_b;
  logic        map_q, disc_q;
  logic [11:0] cost_q, path_q;
  logic [1:0]  par_q;
  logic        p1_valid, p1_beyond;
  logic [1:0]  p1_kind;
  logic [12:0] p1_len;

  logic        out_can, in_fire;
  logic [6:0]  eff_w, eff_h, h0, nh, nx7, ny7;
  logic        nb_ok;
  logic [11:0] n_cell, start_cell, par_hi, m_idx;
  logic [13:0] l14, r14;
  logic        l_ok, r_ok;
  logic [31:0] mk;
  heap_entry_t child;

  logic        map_we, disc_we, cost_we, par_we, heap_we, path_we;
  logic [11:0] map_wa, disc_wa, cost_wa, heap_wa, path_wa, ha, hb;
  logic        map_wd, disc_wd;
  logic [11:0] cost_wd;
  heap_entry_t heap_wd;

  assign out_can    = !out_valid || out_ready;
  assign in_ready   = cmd.idle && (!p1_valid || out_can);
  assign in_fire    = in_valid && in_ready;
  assign start_cell = {sy, sx};

  always_comb begin
    eff_w = (grid_width == 7'd0) ? 7'd1 :
            (grid_width > 7'(MAX_WIDTH)) ? 7'(MAX_WIDTH) : grid_width;
    eff_h = (grid_height == 7'd0) ? 7'd1 :
            (grid_height > 7'(MAX_HEIGHT)) ? 7'(MAX_HEIGHT) : grid_height;
    h0 = 7'(abs_diff(sx, gx)) + 7'(abs_diff(sy, gy));
  end

  // Neighbour of the current cell in direction dir.
  always_comb begin
    nx7   = {1'b0, cur[5:0]};
    ny7   = {1'b0, cur[11:6]};
    nb_ok = 1'b1;
    case (dir)
      DIR_XP: nx7 = {1'b0, cur[5:0]} + 7'd1;
      DIR_XM: begin
        nb_ok = (cur[5:0] != 6'd0);
        nx7   = {1'b0, cur[5:0]} - 7'd1;
      end
      DIR_YP: ny7 = {1'b0, cur[11:6]} + 7'd1;
      default: begin
        nb_ok = (cur[11:6] != 6'd0);
        ny7   = {1'b0, cur[11:6]} - 7'd1;
      end
    endcase
    nb_ok  = nb_ok && (nx7 < eff_w) && (ny7 < eff_h);
    n_cell = {ny7[5:0], nx7[5:0]};
    nh     = 7'(abs_diff(nx7[5:0], gx)) + 7'(abs_diff(ny7[5:0], gy));
  end

  // Heap index arithmetic and the sift-down choice.
  always_comb begin
    par_hi = (hi - 12'd1) >> 1;
    l14    = {1'b0, hi, 1'b1};
    r14    = l14 + 14'd1;
    l_ok   = (l14 < {1'b0, open_count}) && (key_of(rd_a) < key_of(last));
    mk     = l_ok ? key_of(rd_a) : key_of(last);
    r_ok   = (r14 < {1'b0, open_count}) && (key_of(rd_b) < mk);
    child  = r_ok ? rd_b : rd_a;
    m_idx  = r_ok ? r14[11:0] : l14[11:0];
  end

  always_comb begin
    st.search_go  = in_fire && (kind == KIND_SEARCH);
    st.sweep_done = (sweep_cnt == '1);
    st.bad_range  = ({1'b0, sx} >= eff_w) || ({1'b0, sy} >= eff_h) ||
                    ({1'b0, gx} >= eff_w) || ({1'b0, gy} >= eff_h);
    st.oc_zero    = (open_count == 13'd0);
    st.oc_one     = (open_count == 13'd1);
    st.parent_le  = (key_of(rd_a) <= key_of(ne));
    st.par_zero   = (par_hi == 12'd0);
    st.sift_stop  = !l_ok && !r_ok;
    st.at_goal    = (cur == {gy, gx});
    st.nb_ok      = nb_ok;
    st.nb_free    = !map_q && !disc_q;
    st.dir_last   = (dir == DIR_YM);
    st.tr_last    = (tr_i == 13'd1);
    st.out_free   = !p1_valid && out_can;
  end

  // Memory port selection.
  always_comb begin
    map_we  = 1'b0;
    map_wa  = sweep_cnt;
    map_wd  = 1'b0;
    disc_we = 1'b0;
    disc_wa = sweep_cnt;
    disc_wd = 1'b0;
    cost_we = 1'b0;
    cost_wa = nbr;
    cost_wd = gcur + 12'd1;
    par_we  = 1'b0;
    heap_we = 1'b0;
    heap_wa = hi;
    heap_wd = ne;
    path_we = 1'b0;
    path_wa = 12'(tr_i - 13'd1);
    ha      = 12'd0;
    hb      = 12'(open_count - 13'd1);
    if (cmd.op == OP_CLEAR && cmd.clr_map) begin
      map_we = 1'b1;
    end else if (in_fire && kind == KIND_MAP) begin
      map_we = 1'b1;
      map_wa = {cell_y, cell_x};
      map_wd = blocked;
    end
    case (cmd.op)
      OP_CLEAR: disc_we = 1'b1;
      OP_CHECK: begin
        disc_we = !st.bad_range;
        disc_wa = start_cell;
        disc_wd = 1'b1;
        cost_we = !st.bad_range;
        cost_wa = start_cell;
        cost_wd = 12'd0;
      end
      OP_NB_CHK: begin
        disc_we = st.nb_free;
        disc_wa = nbr;
        disc_wd = 1'b1;
        cost_we = st.nb_free;
        par_we  = st.nb_free;
      end
      OP_PUSH_INIT: begin
        heap_we = st.oc_zero;
        heap_wa = 12'd0;
      end
      OP_PUSH_RD: ha = par_hi;
      OP_PUSH_CMP: begin
        heap_we = 1'b1;
        heap_wd = st.parent_le ? ne : rd_a;
      end
      OP_PUSH_PLACE: heap_we = 1'b1;
      OP_SIFT_RD: begin
        ha = l14[11:0];
        hb = r14[11:0];
      end
      OP_SIFT_CMP: begin
        heap_we = 1'b1;
        heap_wd = st.sift_stop ? last : child;
      end
      OP_TR_WR: path_we = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (map_we) map_mem[map_wa] <= map_wd;
    map_q <= map_mem[n_cell];
  end

  always_ff @(posedge clk) begin
    if (disc_we) disc_mem[disc_wa] <= disc_wd;
    disc_q <= disc_mem[n_cell];
  end

  always_ff @(posedge clk) begin
    if (cost_we) cost_mem[cost_wa] <= cost_wd;
    cost_q <= cost_mem[cur];
  end

  always_ff @(posedge clk) begin
    if (par_we) par_mem[nbr] <= dir;
    par_q <= par_mem[tr_cell];
  end

  always_ff @(posedge clk) begin
    if (heap_we) heap_mem[heap_wa] <= heap_wd;
    rd_a <= heap_mem[ha];
    rd_b <= heap_mem[hb];
  end

  always_ff @(posedge clk) begin
    if (path_we) path_mem[path_wa] <= tr_cell;
    if (in_fire) path_q <= path_mem[path_index];
  end

  // Control registers and the output stages.
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width  <= 7'(MAX_WIDTH);
      grid_height <= 7'(MAX_HEIGHT);
      sweep_cnt   <= '0;
      open_count  <= '0;
      seq         <= '0;
      path_count  <= '0;
      p1_valid    <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (cfg_write) begin
        if (cfg_index == CFG_GRID_WIDTH) grid_width <= cfg_data;
        else grid_height <= cfg_data;
      end
      if (in_fire && kind != KIND_SEARCH) p1_valid <= 1'b1;
      else if (p1_valid && out_can) p1_valid <= 1'b0;
      if (st.search_go) begin
        open_count <= '0;
        seq        <= '0;
        path_count <= '0;
      end
      case (cmd.op)
        OP_CLEAR: sweep_cnt <= sweep_cnt + 12'd1;
        OP_PUSH_INIT: begin
          open_count <= open_count + 13'd1;
          seq        <= seq + 12'd1;
        end
        OP_POP_TOP: open_count <= open_count - 13'd1;
        OP_TR_WR: if (st.tr_last) path_count <= 13'(gcur) + 13'd1;
        default: ;
      endcase
      if (p1_valid && out_can) begin
        out_valid <= 1'b1;
      end else if (cmd.op == OP_FINISH && st.out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      p1_kind   <= kind;
      p1_beyond <= !({1'b0, path_index} < path_count);
      p1_len    <= path_count;
    end
    if (st.search_go) begin
      sx <= start_x;
      sy <= start_y;
      gx <= goal_x;
      gy <= goal_y;
    end
    if (p1_valid && out_can) begin
      path_length <= p1_len;
      if (p1_kind == KIND_READ && !p1_beyond) begin
        status <= ST_ACK;
        path_x <= path_q[5:0];
        path_y <= path_q[11:6];
      end else begin
        status <= (p1_kind == KIND_READ) ? ST_BEYOND : ST_ACK;
        path_x <= '0;
        path_y <= '0;
      end
    end else if (cmd.op == OP_FINISH && st.out_free) begin
      status      <= cmd.result;
      path_length <= path_count;
      path_x      <= '0;
      path_y      <= '0;
    end
    case (cmd.op)
      OP_CHECK: ne <= '{f: 13'(h0), h: h0, seq: seq, loc: start_cell};
      OP_PUSH_INIT: hi <= open_count[11:0];
      OP_PUSH_CMP: if (!st.parent_le) hi <= par_hi;
      OP_POP_TOP: begin
        cur  <= rd_a.loc;
        last <= rd_b;
        hi   <= '0;
      end
      OP_SIFT_CMP: if (!st.sift_stop) hi <= m_idx;
      OP_COST_Q: begin
        gcur    <= cost_q;
        dir     <= DIR_XP;
        tr_i    <= 13'(cost_q) + 13'd1;
        tr_cell <= cur;
      end
      OP_NB: begin
        nbr   <= n_cell;
        nbr_h <= nh;
      end
      OP_NB_CHK: if (st.nb_free) begin
        ne <= '{f: 13'(gcur) + 13'd1 + 13'(nbr_h), h: nbr_h, seq: seq, loc: nbr};
      end
      OP_NEXT_DIR: dir <= dir + 2'd1;
      OP_TR_WR: tr_i <= tr_i - 13'd1;
      OP_TR_MOV: begin
        case (par_q)
          DIR_XP: tr_cell <= tr_cell - 12'd1;
          DIR_XM: tr_cell <= tr_cell + 12'd1;
          DIR_YP: tr_cell <= tr_cell - 12'(MAX_WIDTH);
          default: tr_cell <= tr_cell + 12'(MAX_WIDTH);
        endcase
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/gaps_ctrl.sv =====
// Sequencer of the path search: clearing, heap push and pop, expansion and trace-back.
`timescale 1ns / 1ps
`default_nettype none
module gaps_ctrl import gaps_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  stat_t st,
  output cmd_t  cmd
);

  typedef enum logic [4:0] {
    S_CLEAR, S_IDLE, S_CHECK, S_PUSH_INIT, S_PUSH_RD, S_PUSH_CMP, S_PUSH_PLACE,
    S_POP_RD, S_POP_TOP, S_SIFT_RD, S_SIFT_CMP, S_COST_RD, S_COST_Q, S_NB,
    S_NB_CHK, S_NEXT_DIR, S_TR_WR, S_TR_MOV, S_FINISH
  } state_t;

  state_t     state;
  logic       clr_map;
  logic       ret_dir;
  logic [1:0] result;
  state_t     ret_state;

  assign ret_state = ret_dir ? S_NEXT_DIR : S_POP_RD;

  always_comb begin
    cmd.idle    = (state == S_IDLE);
    cmd.clr_map = clr_map;
    cmd.result  = result;
    case (state)
      S_CLEAR:      cmd.op = OP_CLEAR;
      S_IDLE:       cmd.op = OP_IDLE;
      S_CHECK:      cmd.op = OP_CHECK;
      S_PUSH_INIT:  cmd.op = OP_PUSH_INIT;
      S_PUSH_RD:    cmd.op = OP_PUSH_RD;
      S_PUSH_CMP:   cmd.op = OP_PUSH_CMP;
      S_PUSH_PLACE: cmd.op = OP_PUSH_PLACE;
      S_POP_RD:     cmd.op = OP_POP_RD;
      S_POP_TOP:    cmd.op = OP_POP_TOP;
      S_SIFT_RD:    cmd.op = OP_SIFT_RD;
      S_SIFT_CMP:   cmd.op = OP_SIFT_CMP;
      S_COST_RD:    cmd.op = OP_COST_RD;
      S_COST_Q:     cmd.op = OP_COST_Q;
      S_NB:         cmd.op = OP_NB;
      S_NB_CHK:     cmd.op = OP_NB_CHK;
      S_NEXT_DIR:   cmd.op = OP_NEXT_DIR;
      S_TR_WR:      cmd.op = OP_TR_WR;
      S_TR_MOV:     cmd.op = OP_TR_MOV;
      S_FINISH:     cmd.op = OP_FINISH;
      default:      cmd.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_map <= 1'b1;
      ret_dir <= 1'b0;
      result  <= ST_ACK;
    end else begin
      case (state)
        S_CLEAR: if (st.sweep_done) begin
          state   <= clr_map ? S_IDLE : S_CHECK;
          clr_map <= 1'b0;
        end
        S_IDLE: if (st.search_go) state <= S_CLEAR;
        S_CHECK: begin
          if (st.bad_range) begin
            result <= ST_NOPATH;
            state  <= S_FINISH;
          end else begin
            ret_dir <= 1'b0;
            state   <= S_PUSH_INIT;
          end
        end
        S_PUSH_INIT: state <= st.oc_zero ? ret_state : S_PUSH_RD;
        S_PUSH_RD:   state <= S_PUSH_CMP;
        S_PUSH_CMP: begin
          if (st.parent_le) state <= ret_state;
          else if (st.par_zero) state <= S_PUSH_PLACE;
          else state <= S_PUSH_RD;
        end
        S_PUSH_PLACE: state <= ret_state;
        S_POP_RD: begin
          if (st.oc_zero) begin
            result <= ST_NOPATH;
            state  <= S_FINISH;
          end else begin
            state <= S_POP_TOP;
          end
        end
        S_POP_TOP:  state <= st.oc_one ? S_COST_RD : S_SIFT_RD;
        S_SIFT_RD:  state <= S_SIFT_CMP;
        S_SIFT_CMP: state <= st.sift_stop ? S_COST_RD : S_SIFT_RD;
        S_COST_RD:  state <= S_COST_Q;
        S_COST_Q:   state <= st.at_goal ? S_TR_WR : S_NB;
        S_NB:       state <= st.nb_ok ? S_NB_CHK : S_NEXT_DIR;
        S_NB_CHK: begin
          if (st.nb_free) begin
            ret_dir <= 1'b1;
            state   <= S_PUSH_INIT;
          end else begin
            state <= S_NEXT_DIR;
          end
        end
        S_NEXT_DIR: state <= st.dir_last ? S_POP_RD : S_NB;
        S_TR_WR: begin
          if (st.tr_last) begin
            result <= ST_FOUND;
            state  <= S_FINISH;
          end else begin
            state <= S_TR_MOV;
          end
        end
        S_TR_MOV: state <= S_TR_WR;
        S_FINISH: if (st.out_free) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/grid_astar_path_search_core.sv =====
// Top level of the occupancy grid A* path search core.
// The block takes items on a valid/ready input channel and returns exactly one
// result item per input item on a valid/ready output channel, in order.
// A map item (kind 0) marks one grid cell blocked or free; a path read item
// (kind 2) returns one cell of the last found path. Both are accepted one per
// cycle while the block is idle and the output is not stalled, and their results
// pass through a read stage and the output register.
// A search item (kind 1) holds the input channel closed until its result has
// been loaded. It first sweeps the discovered flags, then runs the search: each
// heap push or pop reads and compares once per level climbed or descended, each
// neighbour is checked and pushed if free, and the trace-back writes one path
// cell per move. The registered heap reads give each level a read and a compare step.
// After reset the block clears the whole map and flag memory before it accepts
// its first item; configuration writes are taken throughout. Grid width and
// height reset to 64.
// When the receiver stalls, the finished result waits in the output register
// while one further map or read item may sit in the read stage; the input then
// closes until the output moves.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module grid_astar_path_search_core import gaps_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic        blocked,
  input  logic [5:0]  start_x,
  input  logic [5:0]  start_y,
  input  logic [5:0]  goal_x,
  input  logic [5:0]  goal_y,
  input  logic [11:0] path_index,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [12:0] path_length,
  output logic [5:0]  path_x,
  output logic [5:0]  path_y
);

  cmd_t  cmd;
  stat_t st;

  // The sequencer only steers; all memories and arithmetic sit in the datapath.
  gaps_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .cmd (cmd)
  );

  gaps_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .cfg_write   (cfg_write),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .kind        (kind),
    .cell_x      (cell_x),
    .cell_y      (cell_y),
    .blocked     (blocked),
    .start_x     (start_x),
    .start_y     (start_y),
    .goal_x      (goal_x),
    .goal_y      (goal_y),
    .path_index  (path_index),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .path_length (path_length),
    .path_x      (path_x),
    .path_y      (path_y)
  );

  // A search item must close the input once it is accepted.
  `GAPS_ASSERT_NEXT(a_search_holds, in_valid && in_ready && kind == KIND_SEARCH, !in_ready, "input open during search")
  // A found path always has at least the start cell.
  `GAPS_ASSERT_NOW(a_found_len, out_valid && status == ST_FOUND, path_length != 13'd0, "found path with zero length")
  // A failed search leaves no stored path.
  `GAPS_ASSERT_NOW(a_nopath_len, out_valid && status == ST_NOPATH, path_length == 13'd0, "no path but nonzero length")
  // A read beyond the path returns a zero cell.
  `GAPS_ASSERT_NOW(a_beyond_zero, out_valid && status == ST_BEYOND, path_x == 6'd0 && path_y == 6'd0, "beyond read with nonzero cell")

endmodule
`default_nettype wire
